### design/tpm_pkg.sv
package tpm_pkg;

    // Field widths fixed by the word format
    localparam int COEF_W  = 32;
    localparam int INDEX_W = 6;

    // Input word: one coefficient pair
    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic                     in_last;
    } tpm_in_t;

    // Output word: one product coefficient
    typedef struct packed {
        logic signed [COEF_W-1:0] prod_coef;
        logic [INDEX_W-1:0]       prod_index;
        logic                     out_last;
    } tpm_out_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic load;   // capture coef_a into this cell
        logic shift;  // take b from the left neighbor
        logic clear;  // zero the stored coefficients
    } tpm_cell_ctl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } tpm_state_t;

endpackage

### design/tpm_cell.sv
module tpm_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpm_pkg::tpm_cell_ctl_t      ctl,
    input  logic [tpm_pkg::COEF_W-1:0]  coef_a,
    input  logic [tpm_pkg::COEF_W-1:0]  b_in,
    input  logic [tpm_pkg::COEF_W-1:0]  psum_in,
    output logic [tpm_pkg::COEF_W-1:0]  b_out,
    output logic [tpm_pkg::COEF_W-1:0]  psum_out
);
    import tpm_pkg::*;

    logic [COEF_W-1:0] a_reg;
    logic [COEF_W-1:0] b_reg;
    logic [COEF_W-1:0] prod_reg;
    logic [COEF_W-1:0] psum_reg;

    // Hold this cell's a coefficient; pass b along the delay line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (ctl.clear)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                a_reg <= coef_a;
            end
            if (ctl.shift)
            begin
                b_reg <= b_in;
            end
        end
    end

    // Form the low product word, then add it to the running sum from the left
    always_ff @(posedge clk)
    begin
        prod_reg <= a_reg * b_reg;
        psum_reg <= psum_in + prod_reg;
    end

    assign b_out    = b_reg;
    assign psum_out = psum_reg;

endmodule

### design/truncated_polynomial_multiply.sv
// One coefficient pair is in flight at a time: the partial sum ripples through
// the MAX_POWER+1 cells, one cell per cycle, and the next pair is taken the
// cycle after the result loads. A result that still waits on out_ready holds
// the following one; the input side can still take that following pair, but
// no more until the held result is taken.
// Reset (rst_n low, asynchronous) zeroes stored coefficients, counter and valid.
module truncated_polynomial_multiply #(
    parameter int MAX_POWER = 63
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tpm_pkg::tpm_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tpm_pkg::tpm_out_t out_data
);
    import tpm_pkg::*;

    localparam int Depth   = MAX_POWER + 1;
    localparam int IdxW    = (Depth > 2) ? $clog2(Depth) : 1;
    localparam int CntW    = $clog2(MAX_POWER + 3);
    localparam int IdxExtW = IdxW + INDEX_W;
    localparam logic [IdxW-1:0] MaxIdx  = IdxW'(MAX_POWER);
    localparam logic [CntW-1:0] DoneCnt = CntW'(MAX_POWER + 2);

    tpm_state_t        state_reg, state_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [IdxW-1:0]   idx_reg, idx_next;
    logic [IdxW-1:0]   tag_idx_reg, tag_idx_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    tpm_out_t          out_data_reg, out_data_next;

    logic              accept;
    logic              done;
    logic [IdxExtW-1:0] idx_ext;
    logic [Depth-1:0]  load_vec;

    tpm_cell_ctl_t     cell_ctl [Depth];
    logic [COEF_W-1:0] b_link    [Depth+1];
    logic [COEF_W-1:0] psum_link [Depth+1];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign done     = (state_reg == ST_BUSY) && (cnt_reg == DoneCnt)
                      && (!out_valid_reg || out_ready);

    // Feed the left end of the chain
    assign b_link[0]    = in_data.coef_b;
    assign psum_link[0] = '0;

    // Build the row of cells
    for (genvar i = 0; i < Depth; i++)
    begin : g_cell
        assign load_vec[i]        = accept && (idx_reg == IdxW'(i));
        assign cell_ctl[i].load   = load_vec[i];
        assign cell_ctl[i].shift  = accept;
        assign cell_ctl[i].clear  = done && last_reg;

        tpm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl[i]),
            .coef_a   (in_data.coef_a),
            .b_in     (b_link[i]),
            .psum_in  (psum_link[i]),
            .b_out    (b_link[i+1]),
            .psum_out (psum_link[i+1])
        );
    end

    assign idx_ext = IdxExtW'(tag_idx_reg);

    // Sequence one pair through the row, then hand the sum to the output register
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        tag_idx_next   = tag_idx_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_BUSY;
                    cnt_next     = '0;
                    tag_idx_next = idx_reg;
                    last_next    = in_data.in_last || (idx_reg == MaxIdx);
                end
            end
            ST_BUSY:
            begin
                if (cnt_reg != DoneCnt)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (done)
                begin
                    state_next               = ST_IDLE;
                    out_valid_next           = 1'b1;
                    out_data_next.prod_coef  = psum_link[Depth];
                    out_data_next.prod_index = idx_ext[INDEX_W-1:0];
                    out_data_next.out_last   = last_reg;
                    idx_next = last_reg ? '0 : idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            tag_idx_reg   <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            tag_idx_reg   <= tag_idx_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Exactly one cell captures coef_a per accepted word
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> $onehot(load_vec))
        else $error("coef_a load not one-hot");

    // Power counter never runs past the last cell
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= MaxIdx)
        else $error("power counter out of range");

    // Finishing the last pair restarts the polynomial at power zero
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last_reg) |=> (idx_reg == '0))
        else $error("counter not cleared after last pair");

    // A result is only loaded after the partial sum has crossed the row
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> ($past(cnt_reg) == DoneCnt))
        else $error("result loaded before sum completed");

endmodule
